/* rtl/mlpq_pkg.sv */
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multilevel priority FIFO
// Sizes, status codes, transfer structs and the controller/datapath link.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  // Sizing
  localparam int LEVELS       = 5;
  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 32;

  // Fixed field widths
  localparam int LEVEL_BITS = 3;
  localparam int DATA_BITS  = 32;
  localparam int MASK_BITS  = 5;

  // Derived widths
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORDS   = LEVELS * DEPTH;
  localparam int ADDR_W  = $clog2(WORDS);
  localparam int STORE_W = (PAYLOAD_BITS < DATA_BITS) ? PAYLOAD_BITS : DATA_BITS;
  localparam int EXT_W   = MASK_BITS + LEVELS;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                 kind;
    logic [LEVEL_BITS-1:0] level;
    logic [DATA_BITS-1:0]  payload;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [DATA_BITS-1:0]  data_out;
    logic [LEVEL_BITS-1:0] level_out;
    logic [MASK_BITS-1:0]  empty_mask;
    logic                  all_empty;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic finish_read;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic remove;
  } dp_stat_t;

endpackage

/* rtl/mlpq_ram.sv */
// ----------------------------------------------------------------------------
// mlpq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mlpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mlpq_ctrl: sequencing state machine
// Accepts a request, runs the execute step, waits for the entry read on a
// remove and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module mlpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  mlpq_pkg::dp_stat_t stat,
  output mlpq_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  state_t state;

  // Drive datapath commands
  always_comb begin
    cmd.capture     = start && !busy;
    cmd.execute     = (state == S_EXEC);
    cmd.finish_read = (state == S_READ);
  end

  // Hold state, busy and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state) inside
        S_IDLE, S_RESP: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EXEC: begin
          if (stat.remove) begin
            state <= S_READ;
          end else begin
            state <= S_RESP;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        S_READ: begin
          state <= S_RESP;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/mlpq_dp.sv */
// ----------------------------------------------------------------------------
// mlpq_dp: queue datapath
// Request register, per-level head/tail pointers and fill counts, the shared
// entry store and the result registers.
// ----------------------------------------------------------------------------
module mlpq_dp (
  input  logic               clk,
  input  logic               rst,
  input  mlpq_pkg::req_t     req,
  input  mlpq_pkg::ctl_cmd_t cmd,
  output mlpq_pkg::dp_stat_t stat,
  output mlpq_pkg::rsp_t     rsp
);

  mlpq_pkg::req_t req_q;

  logic [mlpq_pkg::PTR_W-1:0] head_ptr   [mlpq_pkg::LEVELS];
  logic [mlpq_pkg::PTR_W-1:0] tail_ptr   [mlpq_pkg::LEVELS];
  logic [mlpq_pkg::CNT_W-1:0] fill_count [mlpq_pkg::LEVELS];

  mlpq_pkg::status_t                 res_status;
  logic [mlpq_pkg::DATA_BITS-1:0]    res_data;
  logic [mlpq_pkg::LEVEL_BITS-1:0]   res_level;
  logic                              res_found;

  logic [mlpq_pkg::LEVELS-1:0]       empty;
  logic [mlpq_pkg::EXT_W-1:0]        empty_ext;
  logic                              any_full;
  logic [mlpq_pkg::LVL_W-1:0]        sel;
  logic [mlpq_pkg::LVL_W-1:0]        ins_lvl;
  logic                              in_range;
  logic                              ins_full;
  logic                              do_write;
  logic                              do_read;
  logic [mlpq_pkg::ADDR_W-1:0]       waddr;
  logic [mlpq_pkg::ADDR_W-1:0]       raddr;
  logic [mlpq_pkg::STORE_W-1:0]      rdata;

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  assign stat.remove = (req_q.kind == mlpq_pkg::KIND_REMOVE);

  // Flag empty levels and pick the lowest occupied one
  always_comb begin
    sel = '0;
    for (int i = 0; i < mlpq_pkg::LEVELS; i++) begin
      empty[i] = (fill_count[i] == '0);
    end
    for (int i = mlpq_pkg::LEVELS - 1; i >= 0; i--) begin
      if (!empty[i]) begin
        sel = mlpq_pkg::LVL_W'(i);
      end
    end
    any_full = ~&empty;
  end

  // Decode the insert
  assign in_range = ({1'b0, req_q.level} < (mlpq_pkg::LEVEL_BITS + 1)'(mlpq_pkg::LEVELS));
  assign ins_lvl  = req_q.level[mlpq_pkg::LVL_W-1:0];
  assign ins_full = (fill_count[ins_lvl] == mlpq_pkg::CNT_W'(mlpq_pkg::DEPTH));
  assign do_write = cmd.execute && !stat.remove && in_range && !ins_full;
  assign do_read  = cmd.execute && stat.remove && any_full;

  // Form store addresses
  assign waddr = mlpq_pkg::ADDR_W'(ins_lvl) * mlpq_pkg::ADDR_W'(mlpq_pkg::DEPTH)
               + mlpq_pkg::ADDR_W'(tail_ptr[ins_lvl]);
  assign raddr = mlpq_pkg::ADDR_W'(sel) * mlpq_pkg::ADDR_W'(mlpq_pkg::DEPTH)
               + mlpq_pkg::ADDR_W'(head_ptr[sel]);

  mlpq_ram #(
    .WIDTH (mlpq_pkg::STORE_W),
    .WORDS (mlpq_pkg::WORDS)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (waddr),
    .wdata (req_q.payload[mlpq_pkg::STORE_W-1:0]),
    .re    (do_read),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Advance pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mlpq_pkg::LEVELS; i++) begin
        head_ptr[i]   <= '0;
        tail_ptr[i]   <= '0;
        fill_count[i] <= '0;
      end
    end else begin
      if (do_write) begin
        tail_ptr[ins_lvl] <= (tail_ptr[ins_lvl] == mlpq_pkg::PTR_W'(mlpq_pkg::DEPTH - 1))
                           ? '0 : tail_ptr[ins_lvl] + 1'b1;
        fill_count[ins_lvl] <= fill_count[ins_lvl] + 1'b1;
      end
      if (do_read) begin
        head_ptr[sel] <= (head_ptr[sel] == mlpq_pkg::PTR_W'(mlpq_pkg::DEPTH - 1))
                       ? '0 : head_ptr[sel] + 1'b1;
        fill_count[sel] <= fill_count[sel] - 1'b1;
      end
    end
  end

  // Hold the result fields
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_data  <= '0;
      res_level <= '0;
      res_found <= 1'b0;
      if (stat.remove) begin
        if (any_full) begin
          res_status <= mlpq_pkg::ST_OK;
          res_level  <= mlpq_pkg::LEVEL_BITS'(sel);
          res_found  <= 1'b1;
        end else begin
          res_status <= mlpq_pkg::ST_EMPTY;
        end
      end else if (!in_range) begin
        res_status <= mlpq_pkg::ST_RANGE;
      end else if (ins_full) begin
        res_status <= mlpq_pkg::ST_FULL;
      end else begin
        res_status <= mlpq_pkg::ST_OK;
      end
    end else if (cmd.finish_read && res_found) begin
      res_data <= mlpq_pkg::DATA_BITS'(rdata);
    end
  end

  // Report the result with the current empty flags
  assign empty_ext = mlpq_pkg::EXT_W'(empty);

  always_comb begin
    rsp.status     = res_status;
    rsp.data_out   = res_data;
    rsp.level_out  = res_level;
    rsp.empty_mask = empty_ext[mlpq_pkg::MASK_BITS-1:0];
    rsp.all_empty  = &empty;
  end

endmodule

/* rtl/multilevel_priority_fifo.sv */
// ----------------------------------------------------------------------------
// multilevel_priority_fifo: per-level FIFOs served lowest level first
// Inserts append to one level's FIFO, removes pop the head of the lowest
// occupied level; every request yields one result with the empty flags.
//
//   channel   handshake          payload
//   request   start / busy       req  (kind, level, payload)
//   result    done (one cycle)   rsp  (status, data_out, level_out,
//                                      empty_mask, all_empty)
//
// An insert runs through the execute state to its result; a remove adds
// the read state, the registered read of the shared entry store. A new
// request is taken in the cycle its predecessor's result is shown. Reset
// clears the pointers and fill counts at once; the entry store needs no
// clearing. The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mlpq_pkg::req_t req,
  output logic           done,
  output mlpq_pkg::rsp_t rsp
);

  mlpq_pkg::ctl_cmd_t cmd;
  mlpq_pkg::dp_stat_t stat;

  mlpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  mlpq_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
